// ===== sv/ttd_pkg.sv =====
package ttd_pkg;

  // seconds stamp of 2000-01-01 00:00:00 local time
  localparam logic [31:0] BASE_STAMP  = 32'd946656000;

  // 86400 = 128 * 675, so a day count comes from (d >> 7) / 675
  localparam logic [9:0]  DAY_GRAIN   = 10'd675;
  localparam logic [24:0] RECIP_675   = 25'd25451658;  // floor(2^34 / 675)
  localparam logic [17:0] RECIP_60    = 18'd139811;    // ceil(2^23 / 60)
  localparam logic [15:0] RECIP_1461  = 16'd45934;     // ceil(2^26 / 1461)
  localparam logic [16:0] RECIP_7     = 17'd74899;     // ceil(2^19 / 7)

  // 2000-01-01 was a saturday
  localparam logic [16:0] WEEKDAY_BASE = 17'd6;

  // day counts at the start of each year inside a four-year cycle
  localparam logic [10:0] CYC_YEAR1 = 11'd366;
  localparam logic [10:0] CYC_YEAR2 = 11'd731;
  localparam logic [10:0] CYC_YEAR3 = 11'd1096;

  localparam logic [8:0] CUM_DAYS [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // number of datapath steps from a loaded stamp to a settled result
  localparam logic [2:0] NUM_STEPS = 3'd7;

  typedef enum logic [1:0] {
    ST_IN_RANGE  = 2'd0,
    ST_SATURATED = 2'd1,
    ST_BEFORE    = 2'd2
  } range_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic adv;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    range_status_t range_status;
    logic [2:0]    weekday;
    logic [5:0]    second_val;
    logic [5:0]    minute_val;
    logic [4:0]    hour_val;
    logic [4:0]    day_of_month;
    logic [3:0]    month_num;
    logic [6:0]    year_offset;
  } result_t;

endpackage

// ===== sv/ttd_ctrl.sv =====
module ttd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output ttd_pkg::cmd_t cmd
);
  import ttd_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic [2:0]  step_r, step_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      S_IDLE: begin
        step_nxt = '0;
        if (in_tvalid) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        step_nxt = step_r + 3'd1;
        if (step_r == NUM_STEPS - 3'd1) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // result slot frees up when empty or being taken this cycle
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready    = 1'b0;
    cmd.load     = 1'b0;
    cmd.adv      = 1'b0;
    cmd.out_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_RUN: begin
        cmd.adv = 1'b1;
      end
      S_FINISH: begin
        cmd.out_load = !out_valid_r || out_tready;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

`ifndef SYNTHESIS
  a_load_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_RUN && step_r == 3'd0))
    else $error("accepted stamp did not start the step sequence");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (step_r < NUM_STEPS))
    else $error("step counter ran past the last datapath step");

  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("result shown without finishing the sequence");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result register overwritten while still pending");
`endif

endmodule

// ===== sv/ttd_datapath.sv =====
module ttd_datapath #(
  parameter logic [31:0] MAX_STAMP = 32'd4102415990
) (
  input  logic             clk,
  input  logic [31:0]      in_stamp,
  input  ttd_pkg::cmd_t    cmd,
  output ttd_pkg::result_t res
);
  import ttd_pkg::*;

  // stamp capture and range check
  logic [31:0]   d_r, d_nxt;
  range_status_t st_r, st_nxt;

  always_comb begin
    if (in_stamp > MAX_STAMP) begin
      st_nxt = ST_SATURATED;
      d_nxt  = MAX_STAMP - BASE_STAMP;
    end else if (in_stamp < BASE_STAMP) begin
      st_nxt = ST_BEFORE;
      d_nxt  = '0;
    end else begin
      st_nxt = ST_IN_RANGE;
      d_nxt  = in_stamp - BASE_STAMP;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      d_r  <= d_nxt;
      st_r <= st_nxt;
    end
  end

  logic [24:0] grain;
  assign grain = d_r[31:7];

  // step 1: day count estimate
  logic [49:0] p1_r, p1_nxt;
  assign p1_nxt = 50'(grain) * 50'(RECIP_675);

  // step 2: back-multiply the estimate
  logic [15:0] qe_r, qe_nxt;
  logic [25:0] p2_r, p2_nxt;
  assign qe_nxt = p1_r[49:34];
  assign p2_nxt = 26'(p1_r[49:34]) * 26'(DAY_GRAIN);

  // step 3: correct estimate, split into days and second of day
  logic [15:0] days_r, days_nxt;
  logic [16:0] sod_r, sod_nxt;
  logic [25:0] rem3;
  logic [10:0] rr;
  logic        fold;

  always_comb begin
    rem3 = 26'(grain) - p2_r;
    fold = rem3[10:0] >= 11'(DAY_GRAIN);
    if (fold) begin
      days_nxt = qe_r + 16'd1;
      rr       = rem3[10:0] - 11'(DAY_GRAIN);
    end else begin
      days_nxt = qe_r;
      rr       = rem3[10:0];
    end
    sod_nxt = {rr[9:0], d_r[6:0]};
  end

  // step 4: reciprocal products for minutes, four-year cycles and weekday
  logic [33:0] pm_r, pm_nxt;
  logic [31:0] py_r, py_nxt;
  logic [33:0] pw_r, pw_nxt;
  logic [16:0] wx;

  assign wx     = 17'(days_r) + WEEKDAY_BASE;
  assign pm_nxt = 34'(sod_r) * 34'(RECIP_60);
  assign py_nxt = 32'(days_r) * 32'(RECIP_1461);
  assign pw_nxt = 34'(wx) * 34'(RECIP_7);

  // step 5: seconds, minute count, cycle index, weekday
  logic [10:0] mins_r, mins_nxt;
  logic [5:0]  sec_r, sec_nxt;
  logic [27:0] ph_r, ph_nxt;
  logic [4:0]  cyc_r, cyc_nxt;
  logic [10:0] r1461_r, r1461_nxt;
  logic [2:0]  wd_r, wd_nxt;

  assign mins_nxt  = pm_r[33:23];
  assign sec_nxt   = 6'(sod_r - 17'(pm_r[33:23]) * 17'd60);
  assign ph_nxt    = 28'(pm_r[33:23]) * 28'(RECIP_60);
  assign cyc_nxt   = py_r[30:26];
  assign r1461_nxt = 11'(days_r - 16'(py_r[30:26]) * 16'd1461);
  assign wd_nxt    = 3'(wx - 17'(pw_r[33:19]) * 17'd7);

  // step 6: hour, minute, year and day of year
  logic [4:0] hr_r, hr_nxt;
  logic [5:0] min_r, min_nxt;
  logic [6:0] yr_r, yr_nxt;
  logic [8:0] doy_r, doy_nxt;
  logic       leap_r, leap_nxt;
  logic [1:0] yi;
  logic [10:0] ybase;

  assign hr_nxt  = ph_r[27:23];
  assign min_nxt = 6'(mins_r - 11'(ph_r[27:23]) * 11'd60);

  always_comb begin
    if (r1461_r < CYC_YEAR1) begin
      yi    = 2'd0;
      ybase = '0;
    end else if (r1461_r < CYC_YEAR2) begin
      yi    = 2'd1;
      ybase = CYC_YEAR1;
    end else if (r1461_r < CYC_YEAR3) begin
      yi    = 2'd2;
      ybase = CYC_YEAR2;
    end else begin
      yi    = 2'd3;
      ybase = CYC_YEAR3;
    end
    yr_nxt   = {cyc_r, yi};
    doy_nxt  = 9'(r1461_r - ybase);
    leap_nxt = (yi == 2'd0);
  end

  // step 7: month and day of month
  logic [3:0] mon_r, mon_nxt;
  logic [4:0] dom_r, dom_nxt;

  always_comb begin
    logic [8:0] c;
    logic [8:0] mbase;
    mon_nxt = 4'd1;
    mbase   = '0;
    for (int i = 1; i < 12; i++) begin
      c = CUM_DAYS[i] + ((leap_r && i >= 2) ? 9'd1 : 9'd0);
      if (c <= doy_r) begin
        mon_nxt = 4'(i + 1);
        mbase   = c;
      end
    end
    dom_nxt = 5'(doy_r - mbase + 9'd1);
  end

  always_ff @(posedge clk) begin
    if (cmd.adv) begin
      p1_r    <= p1_nxt;
      qe_r    <= qe_nxt;
      p2_r    <= p2_nxt;
      days_r  <= days_nxt;
      sod_r   <= sod_nxt;
      pm_r    <= pm_nxt;
      py_r    <= py_nxt;
      pw_r    <= pw_nxt;
      mins_r  <= mins_nxt;
      sec_r   <= sec_nxt;
      ph_r    <= ph_nxt;
      cyc_r   <= cyc_nxt;
      r1461_r <= r1461_nxt;
      wd_r    <= wd_nxt;
      hr_r    <= hr_nxt;
      min_r   <= min_nxt;
      yr_r    <= yr_nxt;
      doy_r   <= doy_nxt;
      leap_r  <= leap_nxt;
      mon_r   <= mon_nxt;
      dom_r   <= dom_nxt;
    end
  end

  // result register
  result_t res_r, res_nxt;

  always_comb begin
    res_nxt.range_status = st_r;
    if (st_r == ST_BEFORE) begin
      res_nxt.weekday      = '0;
      res_nxt.second_val   = '0;
      res_nxt.minute_val   = '0;
      res_nxt.hour_val     = '0;
      res_nxt.day_of_month = '0;
      res_nxt.month_num    = '0;
      res_nxt.year_offset  = '0;
    end else begin
      res_nxt.weekday      = wd_r;
      res_nxt.second_val   = sec_r;
      res_nxt.minute_val   = min_r;
      res_nxt.hour_val     = hr_r;
      res_nxt.day_of_month = dom_r;
      res_nxt.month_num    = mon_r;
      res_nxt.year_offset  = yr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== sv/timestamp_to_date_time_unit.sv =====
// Converts a 32-bit seconds stamp (local time, UTC+8) into year offset from 2000, month, day,
// hour, minute, second and weekday (0 is sunday). Stamps past 12-31 23:59:50 of year
// YEAR_SPAN-1 give that time with range status 1; stamps before 2000 give all-zero fields
// with range status 2. One stamp is converted at a time: the stamp is captured at its
// transfer edge, passes the seven steps of the reciprocal-multiply datapath and then fills
// the result register once that register has been emptied or is being read; only after
// that fill is the next stamp taken.
module timestamp_to_date_time_unit #(
  parameter int unsigned YEAR_SPAN = 100
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // stamp
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // year_offset, month_num, day_of_month, hour_val,
                                  // minute_val, second_val, weekday, zero fill
  output logic [1:0]  out_tuser   // range_status
);
  import ttd_pkg::*;

  localparam longint unsigned MaxStampL = 64'd946656000
    + 64'd86400 * (64'd365 * YEAR_SPAN + (64'(YEAR_SPAN) + 64'd3) / 64'd4) - 64'd10;
  localparam logic [31:0] MaxStamp = 32'(MaxStampL);

  cmd_t    cmd;
  result_t res;

  ttd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  ttd_datapath #(
    .MAX_STAMP (MaxStamp)
  ) u_datapath (
    .clk      (clk),
    .in_stamp (in_tdata),
    .cmd      (cmd),
    .res      (res)
  );

  assign out_tdata = {4'b0000, res.weekday, res.second_val, res.minute_val, res.hour_val,
                      res.day_of_month, res.month_num, res.year_offset};
  assign out_tuser = res.range_status;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import ttd_pkg::*;

  localparam int unsigned YEAR_SPAN = 100;
  localparam int unsigned SECS_PER_DAY = 86400;
  localparam int RANDOM_STAMPS = 480;
  localparam int TAIL_ITEMS = 40;
  localparam int STALL_AFTER = 120;
  localparam int STALL_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 20;

  // month offset terms of the weekday formula, common and leap years
  localparam logic [2:0] WK_COMMON [12] = '{6, 2, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
  localparam logic [2:0] WK_LEAP [12] = '{5, 1, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // stamp
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // year_offset, month_num, day_of_month, hour_val,
                                // minute_val, second_val, weekday, zero fill
  logic [1:0]  out_tuser;       // range_status

  logic [31:0] stamp_queue [$];
  result_t     pending_dates [$];

  int stamps_sent = 0;
  int dates_checked = 0;
  int total_stamps = 0;
  int mismatches = 0;
  int tx_gap = 0;
  int rx_gap = 0;
  int stall_left = 0;
  bit stall_done = 1'b0;
  int idle_cycles = 0;
  int in_range_cnt = 0;
  int saturated_cnt = 0;
  int before_cnt = 0;

  timestamp_to_date_time_unit #(
    .YEAR_SPAN(YEAR_SPAN)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #10 clk = ~clk;

  function automatic longint unsigned year_start_secs(int unsigned yr);
    longint unsigned days;
    days = 365 * longint'(yr) + (yr + 3) / 4;
    return longint'(BASE_STAMP) + days * SECS_PER_DAY;
  endfunction

  function automatic int unsigned days_before_month(int unsigned yr, int unsigned idx);
    return CUM_DAYS[idx] + (((yr % 4) == 0 && idx >= 2) ? 1 : 0);
  endfunction

  function automatic logic [2:0] weekday_of(int unsigned yr, int unsigned mo, int unsigned dd);
    int unsigned t;
    t = ((yr % 4) == 0) ? WK_LEAP[mo - 1] : WK_COMMON[mo - 1];
    return 3'((dd + t + ((yr / 4 + yr) % 7)) % 7);
  endfunction

  function automatic result_t convert_stamp(logic [31:0] stamp);
    result_t         r;
    longint unsigned s;
    longint unsigned rem;
    int unsigned     yr;
    int unsigned     mo;
    bit              found;
    r = '0;
    s = longint'(stamp);
    if (s > year_start_secs(YEAR_SPAN) - 10) begin
      yr = YEAR_SPAN - 1;
      r.year_offset  = 7'(yr);
      r.month_num    = 4'd12;
      r.day_of_month = 5'd31;
      r.hour_val     = 5'd23;
      r.minute_val   = 6'd59;
      r.second_val   = 6'd50;
      r.weekday      = weekday_of(yr, 12, 31);
      r.range_status = ST_SATURATED;
    end else if (s < longint'(BASE_STAMP)) begin
      r.range_status = ST_BEFORE;
    end else begin
      yr = 0;
      for (int unsigned i = 1; i < YEAR_SPAN; i++) begin
        if (year_start_secs(i) <= s) yr = i;
      end
      rem = s - year_start_secs(yr);
      r.second_val = 6'(rem % 60);
      rem = rem / 60;
      r.minute_val = 6'(rem % 60);
      rem = rem / 60;
      r.hour_val = 5'(rem % 24);
      rem = rem / 24;
      mo = 12;
      found = 1'b0;
      for (int unsigned i = 0; i < 12; i++) begin
        if (!found && days_before_month(yr, i) > rem) begin
          mo = i;
          found = 1'b1;
        end
      end
      r.year_offset  = 7'(yr);
      r.month_num    = 4'(mo);
      r.day_of_month = 5'(rem - days_before_month(yr, mo - 1) + 1);
      r.weekday      = weekday_of(yr, mo, rem - days_before_month(yr, mo - 1) + 1);
      r.range_status = ST_IN_RANGE;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
    $display("result %0d: %s expected %0d, got %0d", dates_checked, what, want, got);
    mismatches++;
  endtask

  // stamp driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      tx_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        pending_dates.push_back(convert_stamp(in_tdata));
        stamps_sent <= stamps_sent + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
          in_tvalid <= 1'b0;
        end else if (stamp_queue.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (stamp_queue.size() > TAIL_ITEMS && stall_left == 0 &&
                     $urandom_range(7, 0) == 0) begin
          tx_gap <= $urandom_range(16, 0);
          in_tvalid <= 1'b0;
        end else begin
          in_tvalid <= 1'b1;
          in_tdata <= stamp_queue.pop_front();
        end
      end
    end
  end

  // one long output stall so the unit backs up and holds off its input
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (!stall_done && stamps_sent >= STALL_AFTER) begin
      stall_left <= STALL_CYCLES;
      stall_done <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_gap <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_dates.size() == 0) begin
          report_mismatch("transfer with nothing pending, tdata", 0, out_tdata);
        end else begin
          want = pending_dates.pop_front();
          if (out_tdata[6:0] !== want.year_offset)
            report_mismatch("year_offset", want.year_offset, out_tdata[6:0]);
          if (out_tdata[10:7] !== want.month_num)
            report_mismatch("month_num", want.month_num, out_tdata[10:7]);
          if (out_tdata[15:11] !== want.day_of_month)
            report_mismatch("day_of_month", want.day_of_month, out_tdata[15:11]);
          if (out_tdata[20:16] !== want.hour_val)
            report_mismatch("hour_val", want.hour_val, out_tdata[20:16]);
          if (out_tdata[26:21] !== want.minute_val)
            report_mismatch("minute_val", want.minute_val, out_tdata[26:21]);
          if (out_tdata[32:27] !== want.second_val)
            report_mismatch("second_val", want.second_val, out_tdata[32:27]);
          if (out_tdata[35:33] !== want.weekday)
            report_mismatch("weekday", want.weekday, out_tdata[35:33]);
          if (out_tuser !== want.range_status)
            report_mismatch("range_status", want.range_status, out_tuser);
          case (want.range_status)
            ST_SATURATED: saturated_cnt++;
            ST_BEFORE:    before_cnt++;
            default:      in_range_cnt++;
          endcase
        end
        dates_checked <= dates_checked + 1;
      end
      if (stall_left != 0) begin
        out_tready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap <= rx_gap - 1;
        out_tready <= 1'b0;
      end else if (dates_checked + TAIL_ITEMS < total_stamps &&
                   $urandom_range(7, 0) == 0) begin
        rx_gap <= $urandom_range(16, 0);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("no transfer for %0d cycles, giving up", idle_cycles);
        $display("Mismatches found");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    longint unsigned top;
    longint unsigned ys;
    int unsigned     yr;
    int unsigned     pick;
    int              off;

    top = year_start_secs(YEAR_SPAN) - 10;

    // field extremes, range edges, year and month edges, leap days
    stamp_queue.push_back(32'd0);
    stamp_queue.push_back(32'hFFFF_FFFF);
    stamp_queue.push_back(BASE_STAMP - 1);
    stamp_queue.push_back(BASE_STAMP);
    stamp_queue.push_back(BASE_STAMP + 1);
    stamp_queue.push_back(BASE_STAMP + 59);
    stamp_queue.push_back(BASE_STAMP + SECS_PER_DAY - 1);
    stamp_queue.push_back(32'(year_start_secs(0) + 59 * SECS_PER_DAY));
    stamp_queue.push_back(32'(year_start_secs(0) + 60 * SECS_PER_DAY));
    stamp_queue.push_back(32'(year_start_secs(1) - 1));
    stamp_queue.push_back(32'(year_start_secs(1)));
    stamp_queue.push_back(32'(year_start_secs(2) + 59 * SECS_PER_DAY - 1));
    stamp_queue.push_back(32'(year_start_secs(2) + 59 * SECS_PER_DAY));
    stamp_queue.push_back(32'(year_start_secs(4) + 59 * SECS_PER_DAY + 43210));
    stamp_queue.push_back(32'(year_start_secs(5) - 1));
    stamp_queue.push_back(32'h7FFF_FFFF);
    stamp_queue.push_back(32'h8000_0000);
    stamp_queue.push_back(32'(year_start_secs(YEAR_SPAN - 1)));
    stamp_queue.push_back(32'(top - 1));
    stamp_queue.push_back(32'(top));
    stamp_queue.push_back(32'(top + 1));

    for (int n = 0; n < RANDOM_STAMPS; n++) begin
      pick = $urandom_range(99, 0);
      if (pick < 60) begin
        stamp_queue.push_back($urandom_range(32'(top), BASE_STAMP));
      end else if (pick < 75) begin
        // around a new year
        yr = $urandom_range(YEAR_SPAN - 1, 1);
        off = int'($urandom_range(200, 0)) - 100;
        stamp_queue.push_back(32'(longint'(year_start_secs(yr)) + off));
      end else if (pick < 88) begin
        // around a month change, leap and common years alike
        yr = $urandom_range(YEAR_SPAN - 1, 0);
        ys = year_start_secs(yr) + days_before_month(yr, $urandom_range(11, 1)) * SECS_PER_DAY;
        off = int'($urandom_range(6 * SECS_PER_DAY, 0)) - 3 * int'(SECS_PER_DAY);
        stamp_queue.push_back(32'(longint'(ys) + off));
      end else if (pick < 94) begin
        stamp_queue.push_back($urandom_range(BASE_STAMP - 1, 0));
      end else begin
        stamp_queue.push_back($urandom_range(32'hFFFF_FFFF, 32'(top + 1)));
      end
    end
    total_stamps = stamp_queue.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (stamp_queue.size() != 0 || in_tvalid) @(posedge clk);
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d conversions: %0d in range, %0d saturated, %0d before 2000",
             dates_checked, in_range_cnt, saturated_cnt, before_cnt);
    $display("year, month and leap-day edges plus random idling and one long output stall");
    if (mismatches == 0 && pending_dates.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
